@@ hw/rtl/fsag_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fsag_pkg;

    // Address width of the walk (unit addresses wrap at this width)
    localparam int ADDR_W = 32;

    // Parameter defaults
    localparam int DEF_WRAP_BITS  = 22;
    localparam int DEF_COUNT_BITS = 12;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_STRIDE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_STRIDE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_STRIDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUBE_STRIDE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNITS_PER_SLICE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLICES_PER_PLANE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PLANES_PER_CUBE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CUBE_TOTAL       = 3'd7;

    // Request mode codes
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // One generated address with its flags
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              slice_end;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/four_level_strided_address_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Four-level strided address generator. A start request (mode 0) loads the
// base address and returns it as the first address of a cube/plane/slice/unit
// walk; each advance request (mode 1) returns the next address, with
// o_slice_end on the last unit of a slice and o_last on the final address.
// Units step by unit_stride with 32-bit wrap; slice, plane and cube starts
// step by their strides and are masked to WRAP_BITS bits. A start with any
// count zero, or an advance with no walk running, is consumed with no result.
// Throughput is one request per clock while o_stall is low; each result is
// registered. The clock period is set by the walk-state update: one stride
// add per level plus four counter end compares, with a second add when a
// start and a level step coincide. A two-entry output (result register plus
// skid register) keeps requests flowing while the consumer stalls; o_stall
// rises only when both entries are full. Configuration writes are taken every
// cycle (o_cfg_ready is always high) and must be made while no result is
// outstanding.
module four_level_strided_address_generator #(
    parameter int WRAP_BITS  = fsag_pkg::DEF_WRAP_BITS,
    parameter int COUNT_BITS = fsag_pkg::DEF_COUNT_BITS,
    parameter int CFG_W      = (WRAP_BITS > COUNT_BITS) ? WRAP_BITS : COUNT_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_mode,
    input  wire logic [fsag_pkg::ADDR_W-1:0]    i_base_address,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [fsag_pkg::ADDR_W-1:0]         o_address,
    output logic                                o_slice_end,
    output logic                                o_last,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [fsag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]               i_cfg_data
);

    import fsag_pkg::*;

    localparam logic [ADDR_W-1:0] WRAP_MASK =
        ADDR_W'((64'd1 << WRAP_BITS) - 64'd1);

    // Configuration registers
    logic [WRAP_BITS-1:0]  r_unit_stride;
    logic [WRAP_BITS-1:0]  r_slice_stride;
    logic [WRAP_BITS-1:0]  r_plane_stride;
    logic [WRAP_BITS-1:0]  r_cube_stride;
    logic [COUNT_BITS-1:0] r_units_per_slice;
    logic [COUNT_BITS-1:0] r_slices_per_plane;
    logic [COUNT_BITS-1:0] r_planes_per_cube;
    logic [COUNT_BITS-1:0] r_cube_total;

    // Walk state
    logic [ADDR_W-1:0]     r_cube_start,  n_cube_start;
    logic [ADDR_W-1:0]     r_plane_start, n_plane_start;
    logic [ADDR_W-1:0]     r_slice_start, n_slice_start;
    logic [ADDR_W-1:0]     r_unit_ptr,    n_unit_ptr;
    logic [COUNT_BITS-1:0] r_unit_cnt,    n_unit_cnt;
    logic [COUNT_BITS-1:0] r_slice_cnt,   n_slice_cnt;
    logic [COUNT_BITS-1:0] r_plane_cnt,   n_plane_cnt;
    logic [COUNT_BITS-1:0] r_cube_cnt,    n_cube_cnt;
    logic                  r_active,      n_active;

    // Output buffering
    t_result r_out;
    t_result r_skid;
    t_result n_res;
    logic    r_out_valid;
    logic    r_skid_valid;

    // Effective state for this request (start reloads it)
    logic [ADDR_W-1:0]     e_cube_start;
    logic [ADDR_W-1:0]     e_plane_start;
    logic [ADDR_W-1:0]     e_slice_start;
    logic [ADDR_W-1:0]     e_unit_ptr;
    logic [COUNT_BITS-1:0] e_unit_cnt;
    logic [COUNT_BITS-1:0] e_slice_cnt;
    logic [COUNT_BITS-1:0] e_plane_cnt;
    logic [COUNT_BITS-1:0] e_cube_cnt;

    logic [ADDR_W-1:0] unit_step_w;
    logic [ADDR_W-1:0] slice_step_w;
    logic [ADDR_W-1:0] plane_step_w;
    logic [ADDR_W-1:0] cube_step_w;

    logic is_start;
    logic counts_ok;
    logic gen;
    logic acc;
    logic take;
    logic unit_end, slice_end, plane_end, cube_end;

    // Masked pointer step
    function automatic logic [ADDR_W-1:0] wrap_step(
        input logic [ADDR_W-1:0] start,
        input logic [ADDR_W-1:0] stride
    );
        return (start + stride) & WRAP_MASK;
    endfunction

    // Level end: counter plus one reaches the count
    function automatic logic at_end(
        input logic [COUNT_BITS-1:0] cnt,
        input logic [COUNT_BITS-1:0] num
    );
        return ({1'b0, cnt} + (COUNT_BITS+1)'(1)) >= {1'b0, num};
    endfunction

    // Handshakes
    assign o_stall     = r_skid_valid;
    assign acc         = i_valid & ~o_stall;
    assign take        = r_out_valid & ~i_stall;
    assign o_cfg_ready = 1'b1;

    assign unit_step_w  = ADDR_W'(r_unit_stride);
    assign slice_step_w = ADDR_W'(r_slice_stride);
    assign plane_step_w = ADDR_W'(r_plane_stride);
    assign cube_step_w  = ADDR_W'(r_cube_stride);

    assign is_start  = (i_mode == MODE_START);
    assign counts_ok = (r_units_per_slice != '0) && (r_slices_per_plane != '0) &&
                       (r_planes_per_cube != '0) && (r_cube_total != '0);
    assign gen       = is_start ? counts_ok : r_active;

    // Start reloads all pointers from the base address
    always_comb begin
        if (is_start) begin
            e_unit_ptr    = i_base_address;
            e_slice_start = wrap_step(i_base_address, slice_step_w);
            e_plane_start = wrap_step(i_base_address, plane_step_w);
            e_cube_start  = wrap_step(i_base_address, cube_step_w);
            e_unit_cnt    = '0;
            e_slice_cnt   = '0;
            e_plane_cnt   = '0;
            e_cube_cnt    = '0;
        end else begin
            e_unit_ptr    = r_unit_ptr;
            e_slice_start = r_slice_start;
            e_plane_start = r_plane_start;
            e_cube_start  = r_cube_start;
            e_unit_cnt    = r_unit_cnt;
            e_slice_cnt   = r_slice_cnt;
            e_plane_cnt   = r_plane_cnt;
            e_cube_cnt    = r_cube_cnt;
        end
    end

    assign unit_end  = at_end(e_unit_cnt,  r_units_per_slice);
    assign slice_end = at_end(e_slice_cnt, r_slices_per_plane);
    assign plane_end = at_end(e_plane_cnt, r_planes_per_cube);
    assign cube_end  = at_end(e_cube_cnt,  r_cube_total);

    // Result for this request
    always_comb begin
        n_res.address   = e_unit_ptr;
        n_res.slice_end = unit_end;
        n_res.last      = unit_end & slice_end & plane_end & cube_end;
    end

    // Step the walk: innermost level that is not at its end advances; with all levels at their end the walk ends
    always_comb begin
        n_unit_ptr    = e_unit_ptr;
        n_slice_start = e_slice_start;
        n_plane_start = e_plane_start;
        n_cube_start  = e_cube_start;
        n_unit_cnt    = e_unit_cnt;
        n_slice_cnt   = e_slice_cnt;
        n_plane_cnt   = e_plane_cnt;
        n_cube_cnt    = e_cube_cnt;
        n_active      = 1'b1;
        if (!unit_end) begin
            n_unit_cnt = e_unit_cnt + COUNT_BITS'(1);
            n_unit_ptr = e_unit_ptr + unit_step_w;
        end else if (!slice_end) begin
            n_unit_cnt    = '0;
            n_slice_cnt   = e_slice_cnt + COUNT_BITS'(1);
            n_unit_ptr    = e_slice_start;
            n_slice_start = wrap_step(e_slice_start, slice_step_w);
        end else if (!plane_end) begin
            n_unit_cnt    = '0;
            n_slice_cnt   = '0;
            n_plane_cnt   = e_plane_cnt + COUNT_BITS'(1);
            n_unit_ptr    = e_plane_start;
            n_slice_start = wrap_step(e_plane_start, slice_step_w);
            n_plane_start = wrap_step(e_plane_start, plane_step_w);
        end else if (!cube_end) begin
            n_unit_cnt    = '0;
            n_slice_cnt   = '0;
            n_plane_cnt   = '0;
            n_cube_cnt    = e_cube_cnt + COUNT_BITS'(1);
            n_unit_ptr    = e_cube_start;
            n_slice_start = wrap_step(e_cube_start, slice_step_w);
            n_plane_start = wrap_step(e_cube_start, plane_step_w);
            n_cube_start  = wrap_step(e_cube_start, cube_step_w);
        end else begin
            n_unit_cnt  = '0;
            n_slice_cnt = '0;
            n_plane_cnt = '0;
            n_cube_cnt  = '0;
            n_active    = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_stride      <= '0;
            r_slice_stride     <= '0;
            r_plane_stride     <= '0;
            r_cube_stride      <= '0;
            r_units_per_slice  <= COUNT_BITS'(1);
            r_slices_per_plane <= COUNT_BITS'(1);
            r_planes_per_cube  <= COUNT_BITS'(1);
            r_cube_total       <= COUNT_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_UNIT_STRIDE:      r_unit_stride      <= i_cfg_data[WRAP_BITS-1:0];
                REG_SLICE_STRIDE:     r_slice_stride     <= i_cfg_data[WRAP_BITS-1:0];
                REG_PLANE_STRIDE:     r_plane_stride     <= i_cfg_data[WRAP_BITS-1:0];
                REG_CUBE_STRIDE:      r_cube_stride      <= i_cfg_data[WRAP_BITS-1:0];
                REG_UNITS_PER_SLICE:  r_units_per_slice  <= i_cfg_data[COUNT_BITS-1:0];
                REG_SLICES_PER_PLANE: r_slices_per_plane <= i_cfg_data[COUNT_BITS-1:0];
                REG_PLANES_PER_CUBE:  r_planes_per_cube  <= i_cfg_data[COUNT_BITS-1:0];
                REG_CUBE_TOTAL:       r_cube_total       <= i_cfg_data[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Walk state update on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cube_start  <= '0;
            r_plane_start <= '0;
            r_slice_start <= '0;
            r_unit_ptr    <= '0;
            r_unit_cnt    <= '0;
            r_slice_cnt   <= '0;
            r_plane_cnt   <= '0;
            r_cube_cnt    <= '0;
            r_active      <= 1'b0;
        end else if (acc) begin
            if (gen) begin
                r_cube_start  <= n_cube_start;
                r_plane_start <= n_plane_start;
                r_slice_start <= n_slice_start;
                r_unit_ptr    <= n_unit_ptr;
                r_unit_cnt    <= n_unit_cnt;
                r_slice_cnt   <= n_slice_cnt;
                r_plane_cnt   <= n_plane_cnt;
                r_cube_cnt    <= n_cube_cnt;
                r_active      <= n_active;
            end else if (is_start) begin
                // start with a zero count: walk ends or stays idle
                r_active <= 1'b0;
            end
        end
    end

    // Output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (acc && gen) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (acc && gen) begin
            if (!r_out_valid || take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_address   = r_out.address;
    assign o_slice_end = r_out.slice_end;
    assign o_last      = r_out.last;

    // Checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while result register empty");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && gen && n_res.last) |=> !r_active)
        else $error("walk still running after final address");

    a_last_is_slice_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_slice_end)
        else $error("final address not marked as end of slice");

    a_idle_advance_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !is_start && !r_active && !r_skid_valid && !r_out_valid)
        |=> !r_out_valid)
        else $error("advance with no walk produced a result");

endmodule

`default_nettype wire

@@ verif/tb_four_level_strided_address_generator.sv @@
`timescale 1ns / 1ps

module tb_four_level_strided_address_generator;
    import fsag_pkg::*;

    localparam int WRAP_BITS        = DEF_WRAP_BITS;
    localparam int COUNT_BITS       = DEF_COUNT_BITS;
    localparam int CFG_W            = (WRAP_BITS > COUNT_BITS) ? WRAP_BITS : COUNT_BITS;
    localparam int NUM_REGS         = 8;
    localparam int RANDOM_REQUESTS  = 1000;
    localparam int STEADY_AFTER     = 850;
    localparam int SETTLE_CYCLES    = 4;
    localparam int CYCLE_LIMIT      = 500000;
    localparam logic [WRAP_BITS-1:0]  STRIDE_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    // Predicts the address walk and holds the addresses still owed by the block
    class address_walk_model;
        logic [WRAP_BITS-1:0]  unit_stride, slice_stride, plane_stride, cube_stride;
        logic [COUNT_BITS-1:0] units_per_slice, slices_per_plane, planes_per_cube, cube_total;
        logic [ADDR_W-1:0]     next_cube_start, next_plane_start, next_slice_start, unit_ptr;
        logic [COUNT_BITS-1:0] unit_idx, slice_idx, plane_idx, cube_idx;
        bit                    walking;
        t_result               expected_q[$];
        int                    errors;

        function new();
            unit_stride      = '0;
            slice_stride     = '0;
            plane_stride     = '0;
            cube_stride      = '0;
            units_per_slice  = 1;
            slices_per_plane = 1;
            planes_per_cube  = 1;
            cube_total       = 1;
            next_cube_start  = '0;
            next_plane_start = '0;
            next_slice_start = '0;
            unit_ptr         = '0;
            unit_idx         = '0;
            slice_idx        = '0;
            plane_idx        = '0;
            cube_idx         = '0;
            walking          = 1'b0;
            errors           = 0;
        endfunction

        function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_UNIT_STRIDE:      unit_stride      = data[WRAP_BITS-1:0];
                REG_SLICE_STRIDE:     slice_stride     = data[WRAP_BITS-1:0];
                REG_PLANE_STRIDE:     plane_stride     = data[WRAP_BITS-1:0];
                REG_CUBE_STRIDE:      cube_stride      = data[WRAP_BITS-1:0];
                REG_UNITS_PER_SLICE:  units_per_slice  = data[COUNT_BITS-1:0];
                REG_SLICES_PER_PLANE: slices_per_plane = data[COUNT_BITS-1:0];
                REG_PLANES_PER_CUBE:  planes_per_cube  = data[COUNT_BITS-1:0];
                REG_CUBE_TOTAL:       cube_total       = data[COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // level is done once its index plus one reaches the (possibly lowered) count
        function bit at_end(logic [COUNT_BITS-1:0] idx, logic [COUNT_BITS-1:0] cnt);
            return (int'(idx) + 1) >= int'(cnt);
        endfunction

        // start pointers keep only the low WRAP_BITS bits of each sum
        function logic [ADDR_W-1:0] masked_step(logic [ADDR_W-1:0] start,
                                                logic [WRAP_BITS-1:0] stride);
            logic [ADDR_W-1:0] sum;
            sum = start + ADDR_W'(stride);
            return {{(ADDR_W-WRAP_BITS){1'b0}}, sum[WRAP_BITS-1:0]};
        endfunction

        function void load_cube(logic [ADDR_W-1:0] start);
            unit_ptr         = start;
            next_slice_start = masked_step(start, slice_stride);
            next_plane_start = masked_step(start, plane_stride);
        endfunction

        // move to the next unit, rolling over slice, plane and cube as needed
        function void step_walk();
            logic [ADDR_W-1:0] origin;
            if (!at_end(unit_idx, units_per_slice)) begin
                unit_idx++;
                unit_ptr = unit_ptr + ADDR_W'(unit_stride);
                return;
            end
            unit_idx = '0;
            if (!at_end(slice_idx, slices_per_plane)) begin
                slice_idx++;
                unit_ptr         = next_slice_start;
                next_slice_start = masked_step(next_slice_start, slice_stride);
                return;
            end
            slice_idx = '0;
            if (!at_end(plane_idx, planes_per_cube)) begin
                origin = next_plane_start;
                plane_idx++;
                unit_ptr         = origin;
                next_slice_start = masked_step(origin, slice_stride);
                next_plane_start = masked_step(origin, plane_stride);
                return;
            end
            plane_idx = '0;
            if (!at_end(cube_idx, cube_total)) begin
                origin = next_cube_start;
                cube_idx++;
                load_cube(origin);
                next_cube_start = masked_step(origin, cube_stride);
                return;
            end
            cube_idx = '0;
            walking  = 1'b0;
        endfunction

        // returns 1 when the request owes an address
        function bit note_request(logic mode, logic [ADDR_W-1:0] base);
            t_result r;
            if (mode == MODE_START) begin
                if (units_per_slice == 0 || slices_per_plane == 0 ||
                    planes_per_cube == 0 || cube_total == 0) begin
                    walking = 1'b0;
                    return 1'b0;
                end
                unit_idx  = '0;
                slice_idx = '0;
                plane_idx = '0;
                cube_idx  = '0;
                load_cube(base);
                next_cube_start = masked_step(base, cube_stride);
                walking = 1'b1;
            end else if (!walking) begin
                return 1'b0;
            end
            r.address   = unit_ptr;
            r.slice_end = at_end(unit_idx, units_per_slice);
            r.last      = r.slice_end && at_end(slice_idx, slices_per_plane) &&
                          at_end(plane_idx, planes_per_cube) && at_end(cube_idx, cube_total);
            expected_q.push_back(r);
            step_walk();
            return 1'b1;
        endfunction

        function void check_result(logic [ADDR_W-1:0] address, logic slice_end, logic last);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("address: expected none, actual %h", address);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (address !== want.address) begin
                $error("address: expected %h, actual %h", want.address, address);
                errors++;
            end
            if (slice_end !== want.slice_end) begin
                $error("slice_end: expected %b, actual %b", want.slice_end, slice_end);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %b, actual %b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_mode;
    logic [ADDR_W-1:0]    i_base_address;
    logic                 o_valid;
    logic                 i_stall;
    logic [ADDR_W-1:0]    o_address;
    logic                 o_slice_end;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    address_walk_model model;
    logic [CFG_W-1:0]  cfg_plan [NUM_REGS];
    int                requests_sent;
    int                cycle_count;
    bit                steady;

    four_level_strided_address_generator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_base_address (i_base_address),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_address      (o_address),
        .o_slice_end    (o_slice_end),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 50 MHz clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // consumer backpressure in random bursts, off in the steady tail
    initial begin
        int burst;
        forever begin
            burst = $urandom_range(1, 15);
            i_stall <= !steady && ($urandom_range(0, 2) == 0);
            repeat (burst) @(posedge i_clk);
        end
    end

    // check every accepted address
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            model.check_result(o_address, o_slice_end, o_last);
        end
    end

    task automatic pause_requests(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // one request, with an occasional idle burst ahead of it; valid stays high after
    task automatic send_request(input logic mode, input logic [ADDR_W-1:0] base);
        if (!steady && $urandom_range(0, 5) == 0) begin
            pause_requests($urandom_range(1, 15));
        end
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_base_address <= base;
        do @(posedge i_clk); while (o_stall);
        void'(model.note_request(mode, base));
        requests_sent++;
    endtask

    // write the selected registers from cfg_plan
    task automatic apply_settings(input logic [NUM_REGS-1:0] which);
        for (int i = 0; i < NUM_REGS; i++) begin
            if (which[i]) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= CFG_IDX_W'(i);
                i_cfg_data  <= cfg_plan[i];
                do @(posedge i_clk); while (!o_cfg_ready);
                model.write_config(CFG_IDX_W'(i), cfg_plan[i]);
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every owed address, then let any result-less request finish
    task automatic drain_results();
        while (model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        longint walk_len;
        int     n_adv;
        int     phase_items;
        int     sent;
        int     kind;
        int     pick;

        model            = new();
        requests_sent    = 0;
        steady           = 1'b0;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_mode           <= MODE_START;
        i_base_address   <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= REG_UNIT_STRIDE;
        i_cfg_data       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // advance with no walk, a single-address walk, then advance past its end
        send_request(MODE_ADVANCE, 32'h0000_0000);
        send_request(MODE_START, 32'hFFFF_FFFF);
        send_request(MODE_ADVANCE, 32'hFFFF_FFFF);
        pause_requests(1);
        drain_results();

        // max strides, 2x2x1x2 walk from the top of memory; counts carry junk high bits
        cfg_plan[REG_UNIT_STRIDE]      = CFG_W'(STRIDE_MAX);
        cfg_plan[REG_SLICE_STRIDE]     = CFG_W'(STRIDE_MAX);
        cfg_plan[REG_PLANE_STRIDE]     = CFG_W'(STRIDE_MAX);
        cfg_plan[REG_CUBE_STRIDE]      = CFG_W'(STRIDE_MAX);
        cfg_plan[REG_UNITS_PER_SLICE]  = 22'h3FF002;
        cfg_plan[REG_SLICES_PER_PLANE] = 22'h155002;
        cfg_plan[REG_PLANES_PER_CUBE]  = 22'h2AA001;
        cfg_plan[REG_CUBE_TOTAL]       = 22'h000002;
        apply_settings('1);
        send_request(MODE_START, 32'hFFFF_FFFF);
        repeat (8) send_request(MODE_ADVANCE, 32'h5555_5555);
        pause_requests(1);
        drain_results();

        // zero slice count: start is dropped and the walk stays idle
        cfg_plan[REG_SLICES_PER_PLANE] = '0;
        apply_settings(NUM_REGS'(1) << REG_SLICES_PER_PLANE);
        send_request(MODE_START, 32'hAAAA_AAAA);
        send_request(MODE_ADVANCE, 32'h0000_0000);
        pause_requests(1);
        drain_results();

        // zero strides, max counts; this walk runs on into the random part
        cfg_plan[REG_UNIT_STRIDE]      = '0;
        cfg_plan[REG_SLICE_STRIDE]     = '0;
        cfg_plan[REG_PLANE_STRIDE]     = '0;
        cfg_plan[REG_CUBE_STRIDE]      = '0;
        cfg_plan[REG_UNITS_PER_SLICE]  = CFG_W'(COUNT_MAX);
        cfg_plan[REG_SLICES_PER_PLANE] = CFG_W'(COUNT_MAX);
        cfg_plan[REG_PLANES_PER_CUBE]  = CFG_W'(COUNT_MAX);
        cfg_plan[REG_CUBE_TOTAL]       = CFG_W'(COUNT_MAX);
        apply_settings('1);
        send_request(MODE_START, 32'h0000_0000);
        repeat (2) send_request(MODE_ADVANCE, $urandom());

        // random phases: new settings, then mostly whole walks
        requests_sent = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            steady = (requests_sent >= STEADY_AFTER);
            pause_requests(1);
            drain_results();

            for (int i = REG_UNIT_STRIDE; i <= REG_CUBE_STRIDE; i++) begin
                pick = $urandom_range(0, 5);
                if (pick == 0)      cfg_plan[i] = '0;
                else if (pick == 1) cfg_plan[i] = CFG_W'(STRIDE_MAX);
                else                cfg_plan[i] = CFG_W'($urandom());
            end
            for (int i = REG_UNITS_PER_SLICE; i <= REG_CUBE_TOTAL; i++) begin
                pick = $urandom_range(0, 19);
                cfg_plan[i] = CFG_W'($urandom());
                if (pick == 0)      cfg_plan[i][COUNT_BITS-1:0] = '0;
                else if (pick == 1) cfg_plan[i][COUNT_BITS-1:0] = COUNT_MAX;
                else                cfg_plan[i][COUNT_BITS-1:0] = COUNT_BITS'($urandom_range(1, 3));
            end
            if ($urandom_range(0, 3) == 0) apply_settings(NUM_REGS'($urandom_range(1, 255)));
            else                           apply_settings('1);

            phase_items = $urandom_range(20, 80);
            sent        = 0;
            while (sent < phase_items) begin
                steady = (requests_sent >= STEADY_AFTER);
                kind   = $urandom_range(0, 9);
                if (kind < 7) begin
                    // whole walk, cut short if long, sometimes overrun by an advance or two
                    walk_len = longint'(model.units_per_slice) * model.slices_per_plane *
                               model.planes_per_cube * model.cube_total;
                    if (walk_len == 0)     n_adv = $urandom_range(0, 2);
                    else if (walk_len > 90) n_adv = $urandom_range(1, 90);
                    else                    n_adv = int'(walk_len) - 1 +
                                                ((kind == 0) ? $urandom_range(1, 2) : 0);
                    send_request(MODE_START, $urandom());
                    repeat (n_adv) send_request(MODE_ADVANCE, $urandom());
                    sent += n_adv + 1;
                end else if (kind < 9) begin
                    // carry on with whatever walk is running
                    n_adv = $urandom_range(1, 10);
                    repeat (n_adv) send_request(MODE_ADVANCE, $urandom());
                    sent += n_adv;
                end else begin
                    // noise: random modes
                    n_adv = $urandom_range(1, 6);
                    repeat (n_adv) send_request(1'($urandom_range(0, 1)), $urandom());
                    sent += n_adv;
                end
            end
        end

        pause_requests(1);
        drain_results();
        repeat (8) @(posedge i_clk);
        if (model.errors == 0 && model.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/fsag_pkg.sv
hw/rtl/four_level_strided_address_generator.sv
verif/tb_four_level_strided_address_generator.sv
